[rtl/core/activity_trace_attenuation_top_assert.svh]
// Assertion macros shared by the trace attenuation RTL.
// Synthesis builds define SYNTH and get empty bodies.
`ifndef ACTIVITY_TRACE_ATTENUATION_TOP_ASSERT_SVH
`define ACTIVITY_TRACE_ATTENUATION_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ATTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
// next-cycle implication
`define ATTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ATTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ATTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/atta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atta_pkg
// Shared types, constants and the divider step for trace attenuation.
// ----------------------------------------------------------------------------
package atta_pkg;

	localparam int UNIT_W   = 10;
	localparam int UNITS    = 1 << UNIT_W;
	localparam int VAL_W    = 16;
	localparam int TRACE_W  = 15;
	localparam int RATE_W   = 17;
	localparam int CFG_W    = 17;
	localparam int IDX_W    = 8;
	localparam int DIV_STAGES = 8;

	localparam logic [RATE_W-1:0]  RATE_ONE = 17'd65536;
	localparam logic [VAL_W-1:0]   DIV_ONE  = 16'd4096;

	localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = 8'd0;
	localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = 8'd1;
	localparam logic [IDX_W-1:0] REG_TRACE_RATE = 8'd2;
	localparam logic [IDX_W-1:0] REG_FLUSH_THR  = 8'd3;

	typedef struct packed {
		logic [UNIT_W-1:0]  unit;
		logic               neg;
		logic [VAL_W-1:0]   rem;
		logic [VAL_W-1:0]   nx;
		logic [VAL_W-1:0]   quo;
		logic [VAL_W-1:0]   dvsr;
		logic [TRACE_W-1:0] trace;
	} atta_div_t;

	// One restoring division step: bring in the next dividend bit.
	function automatic atta_div_t div_step(input atta_div_t a);
		atta_div_t      r;
		logic [VAL_W:0] part;
		r    = a;
		part = {a.rem, a.nx[VAL_W-1]};
		r.nx = {a.nx[VAL_W-2:0], 1'b0};
		if (part >= {1'b0, a.dvsr}) begin
			r.rem = VAL_W'(part - {1'b0, a.dvsr});
			r.quo = {a.quo[VAL_W-2:0], 1'b1};
		end else begin
			r.rem = part[VAL_W-1:0];
			r.quo = {a.quo[VAL_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[rtl/core/atta_trace_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atta_trace_mem
// Trace store: one write and one registered read port, cleared after reset.
// ----------------------------------------------------------------------------
module atta_trace_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [atta_pkg::UNIT_W-1:0]   rd_addr,
	output logic [atta_pkg::TRACE_W-1:0]  rd_data,
	input  logic                          wr_en,
	input  logic [atta_pkg::UNIT_W-1:0]   wr_addr,
	input  logic [atta_pkg::TRACE_W-1:0]  wr_data,
	output logic                          cleared
);
	import atta_pkg::*;

	logic [TRACE_W-1:0] mem [UNITS];
	logic [UNIT_W:0]    clr_q;
	logic               we;
	logic [UNIT_W-1:0]  wa;
	logic [TRACE_W-1:0] wd;

	assign cleared = clr_q[UNIT_W];

	// sweep zeros through every entry, then hand the port to write-back
	always_comb begin
		we = wr_en;
		wa = wr_addr;
		wd = wr_data;
		if (!cleared) begin
			we = 1'b1;
			wa = clr_q[UNIT_W-1:0];
			wd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!cleared) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/atta_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atta_div_pipe
// Pipelined restoring divider, two quotient bits per stage, with hazard probe.
// ----------------------------------------------------------------------------
module atta_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	output logic                         in_rdy,
	input  atta_pkg::atta_div_t          in_data,
	output logic                         out_vld,
	input  logic                         out_rdy,
	output atta_pkg::atta_div_t          out_data,
	input  logic [atta_pkg::UNIT_W-1:0]  probe_unit,
	output logic                         probe_hit
);
	import atta_pkg::*;

	logic      stg_v_q [DIV_STAGES];
	atta_div_t stg_d_q [DIV_STAGES];
	logic      en      [DIV_STAGES];

	// a stage loads when it is empty or its successor loads
	always_comb begin
		en[DIV_STAGES-1] = !stg_v_q[DIV_STAGES-1] || out_rdy;
		for (int k = DIV_STAGES-2; k >= 0; k--) begin
			en[k] = !stg_v_q[k] || en[k+1];
		end
	end

	always_comb begin
		probe_hit = 1'b0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (stg_v_q[k] && stg_d_q[k].unit == probe_unit) begin
				probe_hit = 1'b1;
			end
		end
	end

	assign in_rdy   = en[0];
	assign out_vld  = stg_v_q[DIV_STAGES-1];
	assign out_data = stg_d_q[DIV_STAGES-1];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		atta_div_t src;
		logic      src_v;
		if (k == 0) begin : g_first
			assign src   = in_data;
			assign src_v = in_vld;
		end else begin : g_rest
			assign src   = stg_d_q[k-1];
			assign src_v = stg_v_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_v_q[k] <= 1'b0;
			end else if (en[k]) begin
				stg_v_q[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				stg_d_q[k] <= div_step(div_step(src));
			end
		end
	end

endmodule

[rtl/core/activity_trace_attenuation_top.sv]
`timescale 1ns / 1ps
// Each accepted input beat passes the trace read, divider, clamp and product stages
// and the output register. Throughput: one beat per cycle while the output is not
// stalled and no beat in flight names the same unit; a beat whose unit is still in the
// trace read-modify-write loop waits until that unit's trace has been written back.
// Reset: asynchronous, active low; the trace store is then swept to zero, and no
// input beat is taken until the sweep is done.
// ----------------------------------------------------------------------------
// activity_trace_attenuation_top
// Per-unit trace attenuation: out = clamp(x / (1 + trace/4096)); trace moves toward out.
// ----------------------------------------------------------------------------
`include "activity_trace_attenuation_top_assert.svh"

module activity_trace_attenuation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [atta_pkg::IDX_W-1:0]          cfg_index,
	input  logic [atta_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [atta_pkg::UNIT_W-1:0]         unit_index,
	input  logic signed [atta_pkg::VAL_W-1:0]   sample_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [atta_pkg::UNIT_W-1:0]         unit_echo,
	output logic signed [atta_pkg::VAL_W-1:0]   attenuated_value
);
	import atta_pkg::*;

	// ---------------- configuration registers ----------------
	logic signed [VAL_W-1:0] low_q, high_q;
	logic [RATE_W-1:0]       rate_q;
	logic [TRACE_W-1:0]      thr_q;
	logic [RATE_W-1:0]       rate_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 16'sd0;
			high_q <= 16'sd4096;
			rate_q <= 17'd6554;
			thr_q  <= 15'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_LIMIT:  low_q  <= cfg_data[VAL_W-1:0];
				REG_HIGH_LIMIT: high_q <= cfg_data[VAL_W-1:0];
				REG_TRACE_RATE: rate_q <= cfg_data[RATE_W-1:0];
				REG_FLUSH_THR:  thr_q  <= cfg_data[TRACE_W-1:0];
				default: ;
			endcase
		end
	end

	// a weight above one acts as exactly one
	assign rate_eff = (rate_q > RATE_ONE) ? RATE_ONE : rate_q;

	// ---------------- stage control ----------------
	logic en1, en10, en11, en_out;
	logic v1_s1, v_s10, v_s11;
	logic div_rdy, div_vld, hit_div, hit, cleared, accept;
	logic [UNIT_W-1:0] unit_s1, unit_s10, unit_s11;

	assign en_out = !out_valid || !out_stall;
	assign en11   = !v_s11 || en_out;
	assign en10   = !v_s10 || en11;
	assign en1    = !v1_s1 || div_rdy;

	// Hold the input while a beat for the same unit is still in flight:
	// its trace is not written back until it leaves stage 11.
	assign hit = hit_div
		|| (v1_s1 && unit_s1 == unit_index)
		|| (v_s10 && unit_s10 == unit_index)
		|| (v_s11 && unit_s11 == unit_index);

	assign in_stall = !en1 || hit || !cleared;
	assign accept   = in_valid && !in_stall;

	// ---------------- stage 1: trace read ----------------
	logic signed [VAL_W-1:0] x_s1;
	logic [TRACE_W-1:0]      trace_rd;
	logic                    wb_en;
	logic [UNIT_W-1:0]       wb_unit;
	logic [TRACE_W-1:0]      wb_trace;

	atta_trace_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en1),
		.rd_addr (unit_index),
		.rd_data (trace_rd),
		.wr_en   (wb_en),
		.wr_addr (wb_unit),
		.wr_data (wb_trace),
		.cleared (cleared)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			unit_s1 <= unit_index;
			x_s1    <= sample_value;
		end
	end

	// ---------------- stages 2..9: divide |x|*4096 by 4096+trace ----------------
	atta_div_t        div_in, div_out;
	logic [VAL_W-1:0] mag;

	always_comb begin
		mag          = x_s1[VAL_W-1] ? VAL_W'(-x_s1) : VAL_W'(x_s1);
		div_in.unit  = unit_s1;
		div_in.neg   = x_s1[VAL_W-1];
		div_in.rem   = {4'b0, mag[VAL_W-1:4]};
		div_in.nx    = {mag[3:0], 12'b0};
		div_in.quo   = '0;
		div_in.dvsr  = DIV_ONE + {1'b0, trace_rd};
		div_in.trace = trace_rd;
	end

	atta_div_pipe u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (v1_s1),
		.in_rdy     (div_rdy),
		.in_data    (div_in),
		.out_vld    (div_vld),
		.out_rdy    (en10),
		.out_data   (div_out),
		.probe_unit (unit_index),
		.probe_hit  (hit_div)
	);

	// ---------------- stage 10: sign and clamp ----------------
	logic signed [VAL_W-1:0] q_s10;
	logic [TRACE_W-1:0]      trace_s10;
	logic signed [VAL_W-1:0] q_raw, q_clamped;

	always_comb begin
		q_raw = div_out.neg ? VAL_W'(-{1'b0, div_out.quo}) : div_out.quo;
		// low test first, so with crossed limits a value below the low bound resolves to it
		if (q_raw < low_q) begin
			q_clamped = low_q;
		end else if (q_raw > high_q) begin
			q_clamped = high_q;
		end else begin
			q_clamped = q_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en10) begin
			v_s10 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en10) begin
			unit_s10  <= div_out.unit;
			q_s10     <= q_clamped;
			trace_s10 <= div_out.trace;
		end
	end

	// ---------------- stage 11: weighted products ----------------
	logic signed [VAL_W-1:0]         q_s11;
	logic signed [RATE_W+VAL_W:0]    pnew_s11;
	logic [RATE_W+TRACE_W-1:0]       pold_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en11) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en11) begin
			unit_s11 <= unit_s10;
			q_s11    <= q_s10;
			pnew_s11 <= $signed({1'b0, rate_eff}) * q_s10;
			pold_s11 <= (RATE_ONE - rate_eff) * trace_s10;
		end
	end

	// ---------------- write-back and output register ----------------
	logic signed [RATE_W+VAL_W+1:0] sum;
	logic [TRACE_W-1:0]             nt;

	always_comb begin
		sum = (RATE_W+VAL_W+2)'(pnew_s11) + $signed({3'b0, pold_s11});
		// a negative sum truncates to zero or below, which always flushes
		if (sum[RATE_W+VAL_W+1]) begin
			nt = '0;
		end else begin
			nt = sum[TRACE_W+15:16];
		end
		if (nt < thr_q) begin
			nt = '0;
		end
	end

	assign wb_en    = en_out && v_s11;
	assign wb_unit  = unit_s11;
	assign wb_trace = nt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			unit_echo        <= unit_s11;
			attenuated_value <= q_s11;
		end
	end

	// ---------------- checks ----------------
	`ATTA_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, accept, cleared)
	`ATTA_ASSERT_IMP(a_no_unit_overlap, clk, arst_n, accept, !hit_div)
	`ATTA_ASSERT_NXT(a_out_from_s11, clk, arst_n, !out_valid && !v_s11, !out_valid)

endmodule
